### design/fime_pkg.sv
// Shared types and constants for the frame interval median estimator.
// Used by the cell, the sorting chain and the top level.
package fime_pkg;

    localparam int STAMP_W = 64;
    localparam int DUR_W   = 32;

    // Link from one sorting cell to its right-hand neighbor.
    typedef struct packed {
        logic signed [DUR_W-1:0] value;
        logic                    gt;     // cell value is above the new key, or cell is empty
    } cell_link_t;

    // Control sequencer states, one-hot.
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_INSERT = 3'b010,
        ST_FINISH = 3'b100
    } fime_state_t;

endpackage

### design/fime_cell.sv
// One cell of the sorting chain: holds one interval and takes part in an insertion.
// Depends on fime_pkg.
module fime_cell
    import fime_pkg::*;
(
    input  logic                    clk,
    input  logic                    insert_en,
    input  logic                    valid,
    input  logic signed [DUR_W-1:0] key,
    input  cell_link_t              left,
    output cell_link_t              link
);

    logic signed [DUR_W-1:0] value_reg;
    logic signed [DUR_W-1:0] value_next;
    logic                    gt;

    // An empty cell counts as larger than any key.
    assign gt = !valid || (value_reg > key);

    // A displaced cell takes its left neighbor's value when that is also larger, else the key.
    assign value_next = left.gt ? left.value : key;

    always_ff @(posedge clk)
    begin
        if (insert_en && gt)
        begin
            value_reg <= value_next;
        end
    end

    assign link.value = value_reg;
    assign link.gt    = gt;

endmodule

### design/fime_sort_chain.sv
// Row of sorting cells that keeps the current batch of intervals in ascending order.
// Depends on fime_pkg and fime_cell.
module fime_sort_chain
    import fime_pkg::*;
#(
    parameter int DEPTH = 31,
    parameter int CNT_W = 5
)
(
    input  logic                    clk,
    input  logic                    insert_en,
    input  logic [CNT_W-1:0]        count,
    input  logic signed [DUR_W-1:0] key,
    output logic signed [DUR_W-1:0] median
);

    localparam int MID = DEPTH / 2;

    cell_link_t links [DEPTH];

    // Cell zero has no left neighbor, which acts as a value never above the key.
    cell_link_t head;
    assign head.value = '0;
    assign head.gt    = 1'b0;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic cell_valid;
            assign cell_valid = (CNT_W'(i) < count);

            if (i == 0)
            begin : g_first
                fime_cell u_cell (
                    .clk       (clk),
                    .insert_en (insert_en),
                    .valid     (cell_valid),
                    .key       (key),
                    .left      (head),
                    .link      (links[i])
                );
            end
            else
            begin : g_rest
                fime_cell u_cell (
                    .clk       (clk),
                    .insert_en (insert_en),
                    .valid     (cell_valid),
                    .key       (key),
                    .left      (links[i-1]),
                    .link      (links[i])
                );
            end
        end
    endgenerate

    assign median = links[MID].value;

endmodule

### design/frame_interval_median_estimator_top.sv
// Each accepted timestamp goes through accept, insertion into the sorting chain and
// result; the result step waits until the single output register is free to be written.
// The first timestamp after reset only records the stamp and skips insertion. Later ones
// form a 32-bit signed interval that is inserted into a row of WINDOW_SAMPLES sorting
// cells; when the batch is full the middle cell is the median, which replaces a zero
// duration or is averaged (toward zero) with the held one.
// Every timestamp yields exactly one output transaction. No clearing pass is needed.
// Depends on fime_pkg, fime_sort_chain and fime_cell.
module frame_interval_median_estimator_top
    import fime_pkg::*;
#(
    parameter int WINDOW_SAMPLES = 31
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [63:0] timestamp_us
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] frame_duration_us
    output logic        m_tuser     // [0] updated
);

    localparam int CNT_W = $clog2(WINDOW_SAMPLES + 1);

    fime_state_t state_reg, state_next;

    logic [STAMP_W-1:0]      prev_reg;
    logic                    have_prev_reg;
    logic signed [DUR_W-1:0] delta_reg;
    logic [CNT_W-1:0]        count_reg;
    logic signed [DUR_W-1:0] dur_reg;
    logic                    out_valid_reg;
    logic [DUR_W-1:0]        out_data_reg;
    logic                    out_upd_reg;

    logic                    in_fire;
    logic                    out_free;
    logic                    batch_done;
    logic signed [DUR_W-1:0] median;
    logic signed [DUR_W:0]   sum;
    logic signed [DUR_W:0]   sum_adj;
    logic signed [DUR_W-1:0] dur_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign batch_done = (count_reg == CNT_W'(WINDOW_SAMPLES));

    // Sorted batch of intervals.
    fime_sort_chain #(
        .DEPTH (WINDOW_SAMPLES),
        .CNT_W (CNT_W)
    ) u_chain (
        .clk       (clk),
        .insert_en (state_reg == ST_INSERT),
        .count     (count_reg),
        .key       (delta_reg),
        .median    (median)
    );

    // Average at 33 bits, rounding toward zero.
    assign sum      = {median[DUR_W-1], median} + {dur_reg[DUR_W-1], dur_reg};
    assign sum_adj  = sum + (DUR_W+1)'(sum[DUR_W] & sum[0]);
    assign dur_next = (dur_reg == '0) ? median : sum_adj[DUR_W:1];

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = have_prev_reg ? ST_INSERT : ST_FINISH;
                end
            end
            ST_INSERT:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            count_reg     <= '0;
            dur_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire)
            begin
                prev_reg      <= s_tdata;
                have_prev_reg <= 1'b1;
            end
            if (state_reg == ST_INSERT)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (state_reg == ST_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (batch_done)
                begin
                    dur_reg   <= dur_next;
                    count_reg <= '0;
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            delta_reg <= $signed(s_tdata[DUR_W-1:0] - prev_reg[DUR_W-1:0]);
        end
        if (state_reg == ST_FINISH && out_free)
        begin
            out_upd_reg  <= batch_done;
            out_data_reg <= batch_done ? dur_next : dur_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_upd_reg;

endmodule

### design/fime_checker.sv
// Port-level checker for the frame interval median estimator, bound to the top level.
// Depends on frame_interval_median_estimator_top.
module fime_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    // A stalled output transaction stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output transaction dropped while stalled");

    // A stalled output transaction keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("output payload changed while stalled");

    // One timestamp is worked on at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted again while busy");

    // A new result is only produced while the input side is busy.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without a timestamp in work");

endmodule

bind frame_interval_median_estimator_top fime_checker u_fime_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
